// ----- hw/rtl/tpds_pkg.sv -----
// ----------------------------------------------------------------------------
// tpds_pkg
// Types and constants shared by the transparent polygon depth sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package tpds_pkg;

   localparam int MAX_POLYS   = 64;
   localparam int INDEX_W     = 6;
   localparam int OFFSET_W    = 10;
   localparam int DEPTH_W     = 18;
   localparam int COUNTER_W   = 7;
   localparam int INDEX_LIMIT = 64;
   localparam int COUNTER_MAX = 127;

   typedef struct packed {
      logic                is_transparent;
      logic [3:0]          vertex_count;
      logic [DEPTH_W-1:0]  nearest_depth;
      logic                last_poly;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  poly_index;
      logic [OFFSET_W-1:0] vertex_offset;
      logic [DEPTH_W-1:0]  depth;
      logic                list_empty;
      logic                overflow;
      logic                last_result;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [INDEX_W-1:0]  index;
      logic [OFFSET_W-1:0] offset;
      logic [DEPTH_W-1:0]  depth;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      shift_down;
      entry_type fresh;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tpds_cell.sv -----
// ----------------------------------------------------------------------------
// tpds_cell
// One slot of the sort chain. Holds one entry, decides whether a new entry
// lands ahead of it, and moves toward the head during drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tpds_cell
   import tpds_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     prev_entry,
   input  wire logic          prev_ahead,
   input  wire entry_type     next_entry,
   output entry_type          entry,
   output logic               ahead
);

   logic                valid_ff, valid_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   entry_type           load;

   // new word goes ahead of this slot: empty slot, or not nearer than stored
   assign ahead = !valid_ff || (ctrl.fresh.depth >= depth_ff);

   assign entry.valid  = valid_ff;
   assign entry.index  = index_ff;
   assign entry.offset = offset_ff;
   assign entry.depth  = depth_ff;

   always_comb begin
      load = entry;
      if (ctrl.insert && ahead) begin
         load = prev_ahead ? prev_entry : ctrl.fresh;
      end else if (ctrl.shift_down) begin
         load = next_entry;
      end
      valid_in  = load.valid;
      index_in  = load.index;
      offset_in = load.offset;
      depth_in  = load.depth;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff  <= index_in;
      offset_ff <= offset_in;
      depth_ff  <= depth_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/transparent_poly_depth_sort_top.sv -----
// ----------------------------------------------------------------------------
// transparent_poly_depth_sort_top
// Depth sorter for transparent polygons of one mesh, built as an insertion
// chain of cells kept in farthest-first order.
// ----------------------------------------------------------------------------
// One polygon word is taken per cycle while busy is low, independent of how
// full the list is; every cell compares the new depth in parallel and the
// chain shifts by one slot. After the word marked last_poly, busy stays high
// while the chain drains from its head cell, one result word per cycle: one
// word per held entry, or the empty marker alone. Result words are registered
// from the head cell and appear in the cycle after they leave it, each marked
// by rsp_strobe for a single cycle; they come back to back and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module transparent_poly_depth_sort_top
   import tpds_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_word,
   output logic         rsp_strobe,
   output rsp_type      rsp_word
);

   logic                 drain_ff, drain_in;
   logic                 overflow_ff, overflow_in;
   logic [COUNTER_W-1:0] poly_ff, poly_in;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;
   logic                 strobe_ff, strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic          accept, full, drop, do_insert, drain_last;
   cell_ctrl_type ctrl;
   entry_type     chain [MAX_POLYS];
   logic          ahead [MAX_POLYS];
   entry_type     blank;

   assign busy       = drain_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

   assign accept    = start && !drain_ff;
   assign full      = chain[MAX_POLYS-1].valid;
   assign drop      = req_word.is_transparent &&
                      (full || (poly_ff >= COUNTER_W'(INDEX_LIMIT)));
   assign do_insert = accept && req_word.is_transparent && !drop;

   assign blank.valid  = 1'b0;
   assign blank.index  = '0;
   assign blank.offset = '0;
   assign blank.depth  = '0;

   assign ctrl.insert       = do_insert;
   assign ctrl.shift_down   = drain_ff;
   assign ctrl.fresh.valid  = 1'b1;
   assign ctrl.fresh.index  = poly_ff[INDEX_W-1:0];
   assign ctrl.fresh.offset = offset_ff;
   assign ctrl.fresh.depth  = req_word.nearest_depth;

   for (genvar k = 0; k < MAX_POLYS; k++) begin : g_cell
      tpds_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_entry ((k == 0) ? blank : chain[(k == 0) ? 0 : k-1]),
         .prev_ahead ((k == 0) ? 1'b0  : ahead[(k == 0) ? 0 : k-1]),
         .next_entry ((k == MAX_POLYS-1) ? blank
                                          : chain[(k == MAX_POLYS-1) ? k : k+1]),
         .entry      (chain[k]),
         .ahead      (ahead[k])
      );
   end

   assign drain_last = !chain[0].valid || !chain[1].valid;

   always_comb begin
      drain_in    = drain_ff;
      overflow_in = overflow_ff;
      poly_in     = poly_ff;
      offset_in   = offset_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      if (accept) begin
         if (drop) begin
            overflow_in = 1'b1;
         end
         if (req_word.last_poly) begin
            poly_in   = '0;
            offset_in = '0;
            drain_in  = 1'b1;
         end else begin
            offset_in = offset_ff + OFFSET_W'(req_word.vertex_count);
            if (poly_ff < COUNTER_W'(COUNTER_MAX)) begin
               poly_in = poly_ff + COUNTER_W'(1);
            end
         end
      end
      if (drain_ff) begin
         strobe_in            = 1'b1;
         rsp_in.poly_index    = chain[0].valid ? chain[0].index  : '0;
         rsp_in.vertex_offset = chain[0].valid ? chain[0].offset : '0;
         rsp_in.depth         = chain[0].valid ? chain[0].depth  : '0;
         rsp_in.list_empty    = !chain[0].valid;
         rsp_in.overflow      = overflow_ff;
         rsp_in.last_result   = drain_last;
         if (drain_last) begin
            drain_in    = 1'b0;
            overflow_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff    <= 1'b0;
         overflow_ff <= 1'b0;
         poly_ff     <= '0;
         offset_ff   <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         drain_ff    <= drain_in;
         overflow_ff <= overflow_in;
         poly_ff     <= poly_in;
         offset_ff   <= offset_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.list_empty |-> rsp_word.last_result)
      else $error("empty marker not flagged last");

   a_drain_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.last_result |=> rsp_strobe)
      else $error("gap inside result burst");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      chain[1].valid |-> chain[0].valid && (chain[0].depth >= chain[1].depth))
      else $error("chain head out of order");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without drain");
`endif

endmodule

`default_nettype wire
